// File: rtl/aldt_pkg.sv
// ----------------------------------------------------------------------------
// aldt_pkg
// Shared constants and controller/datapath interface types for the audio
// level deviation tracker.
// ----------------------------------------------------------------------------
package aldt_pkg;

	localparam int AVG_DEPTH  = 16;
	localparam int CHUNK_MAX  = 65536;
	localparam int SILENCE    = 128;

	localparam int SMP_W      = 8;
	localparam int LVL_W      = 8;
	localparam int VAR_W      = 9;
	localparam int IN_TDATA_W = 8;
	localparam int OUT_TDATA_W = 32;

	localparam int CNT_W  = $clog2(CHUNK_MAX + 1);
	localparam int SUM_W  = $clog2(CHUNK_MAX * SILENCE + 1);
	localparam int HEAD_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int FILL_W = $clog2(AVG_DEPTH + 1);
	localparam int TOT_W  = $clog2(AVG_DEPTH * SILENCE + 1);

	// shared restoring divider: dividend and divisor widths cover both divisions
	localparam int DIV_W  = (SUM_W > TOT_W) ? SUM_W : TOT_W;
	localparam int DVS_W  = (CNT_W > FILL_W) ? CNT_W : FILL_W;
	localparam int DCNT_W = $clog2(DIV_W + 1);

	typedef struct packed {
		logic acc;        // add accepted sample into the chunk sums
		logic lvl_start;  // load divider with sum / count, clear chunk sums
		logic avg_start;  // load divider with ring total / fill
		logic div_step;   // one divider iteration
		logic lvl_cap;    // capture chunk level, read oldest ring entry
		logic ring_upd;   // write ring, update total, head and fill
		logic out_load;   // load output register
	} aldt_cmd_t;

	typedef struct packed {
		logic close;      // sample being accepted closes the chunk
		logic div_done;   // divider finished all iterations
		logic out_free;   // output register can take a new result
	} aldt_sts_t;

endpackage

// File: rtl/audio_level_deviation_tracker.sv
// ----------------------------------------------------------------------------
// audio_level_deviation_tracker
// Per-chunk mean absolute deviation from 128 with a moving average over the
// last AVG_DEPTH chunk levels.
// ----------------------------------------------------------------------------
// throughput: one sample per cycle inside a chunk
// a closing sample stalls input through two passes of the shared
// one-bit-per-cycle divider, ring read/update and the output load, which waits for a free output register
// reset: arst_n clears sums, ring head/fill/total, fsm and output valid;
// a ring entry only counts toward the total once it has been written
module audio_level_deviation_tracker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [aldt_pkg::IN_TDATA_W-1:0]     s_tdata,   // [7:0] sample
	input  logic                                s_tlast,   // chunk_end
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [aldt_pkg::OUT_TDATA_W-1:0]    m_tdata    // [7:0] chunk_level,
	                                                       // [15:8] average_level,
	                                                       // [24:16] level_variation,
	                                                       // [31:25] zero
);
	import aldt_pkg::*;

	aldt_cmd_t cmd;
	aldt_sts_t sts;

	aldt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	aldt_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

	// levels never exceed full scale deviation
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:0] <= 8'd128) && (m_tdata[15:8] <= 8'd128))
		else $error("level out of range");

	// variation is consistent with level and average
	a_var_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[24:16] == ({1'b0, m_tdata[7:0]} - {1'b0, m_tdata[15:8]})))
		else $error("level variation mismatch");

	// a marked last sample stops input while the chunk is processed
	a_close_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("input accepted during chunk processing");

	// a new result never overwrites one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("pending result overwritten");

endmodule

// File: rtl/aldt_dp.sv
// ----------------------------------------------------------------------------
// aldt_dp
// Datapath: deviation accumulator, shared iterative divider, level ring
// memory with running total, and the output register.
// ----------------------------------------------------------------------------
module aldt_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  aldt_pkg::aldt_cmd_t                 cmd,
	output aldt_pkg::aldt_sts_t                 sts,
	input  logic [aldt_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic                                s_tlast,
	input  logic                                m_tready,
	output logic                                m_tvalid,
	output logic [aldt_pkg::OUT_TDATA_W-1:0]    m_tdata
);
	import aldt_pkg::*;

	logic [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   cnt_inc;
	logic [SMP_W-1:0]   smp;
	logic [LVL_W-1:0]   dev;

	logic [DIV_W-1:0]   quo_q;
	logic [DVS_W:0]     rem_q;
	logic [DVS_W-1:0]   dvs_q;
	logic [DCNT_W-1:0]  dcnt_q;
	logic [DVS_W:0]     rem_sh;
	logic               rem_ge;

	logic [LVL_W-1:0]   ring_mem [AVG_DEPTH];
	logic [LVL_W-1:0]   old_q;
	logic [LVL_W-1:0]   lvl_q;
	logic [HEAD_W-1:0]  head_q;
	logic [FILL_W-1:0]  fill_q;
	logic [TOT_W-1:0]   tot_q;
	logic               full;
	logic [TOT_W:0]     tot_next;

	logic [LVL_W-1:0]   avg;
	logic [VAR_W-1:0]   var_lvl;
	logic               out_vld_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	// |sample - 128|
	assign smp     = s_tdata[SMP_W-1:0];
	assign dev     = (smp >= SMP_W'(SILENCE)) ? (smp - SMP_W'(SILENCE))
	                                          : (SMP_W'(SILENCE) - smp);
	assign cnt_inc = cnt_q + CNT_W'(1);

	assign rem_sh  = {rem_q[DVS_W-1:0], quo_q[DIV_W-1]};
	assign rem_ge  = rem_sh >= {1'b0, dvs_q};

	assign full     = fill_q == FILL_W'(AVG_DEPTH);
	assign tot_next = {1'b0, tot_q} + (TOT_W+1)'(lvl_q)
	                  - (full ? (TOT_W+1)'(old_q) : '0);

	assign avg     = quo_q[LVL_W-1:0];
	assign var_lvl = {1'b0, lvl_q} - {1'b0, avg};

	assign sts.close    = s_tlast || (cnt_inc == CNT_W'(CHUNK_MAX));
	assign sts.div_done = dcnt_q == '0;
	assign sts.out_free = !out_vld_q || m_tready;

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	// control state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			cnt_q     <= '0;
			dcnt_q    <= '0;
			head_q    <= '0;
			fill_q    <= '0;
			tot_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.acc) begin
				sum_q <= sum_q + SUM_W'(dev);
				cnt_q <= cnt_inc;
			end else if (cmd.lvl_start) begin
				sum_q <= '0;
				cnt_q <= '0;
			end
			if (cmd.lvl_start || cmd.avg_start) begin
				dcnt_q <= DCNT_W'(DIV_W);
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q - DCNT_W'(1);
			end
			if (cmd.ring_upd) begin
				tot_q  <= tot_next[TOT_W-1:0];
				head_q <= (head_q == HEAD_W'(AVG_DEPTH - 1)) ? '0 : head_q + HEAD_W'(1);
				if (!full) begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// divider, ring and output payload
	always_ff @(posedge clk) begin
		if (cmd.lvl_start) begin
			quo_q <= DIV_W'(sum_q);
			dvs_q <= DVS_W'(cnt_q);
			rem_q <= '0;
		end else if (cmd.avg_start) begin
			quo_q <= DIV_W'(tot_q);
			dvs_q <= DVS_W'(fill_q);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[DIV_W-2:0], rem_ge};
			rem_q <= rem_ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
		end
		if (cmd.lvl_cap) begin
			lvl_q <= quo_q[LVL_W-1:0];
			old_q <= ring_mem[head_q];
		end
		if (cmd.ring_upd) begin
			ring_mem[head_q] <= lvl_q;
		end
		if (cmd.out_load) begin
			out_data_q <= OUT_TDATA_W'({var_lvl, avg, lvl_q});
		end
	end

endmodule

// File: rtl/aldt_ctrl.sv
// ----------------------------------------------------------------------------
// aldt_ctrl
// Controller: accepts samples, then sequences level division, ring update,
// average division and the output load for each closed chunk.
// ----------------------------------------------------------------------------
module aldt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output aldt_pkg::aldt_cmd_t  cmd,
	input  aldt_pkg::aldt_sts_t  sts
);
	import aldt_pkg::*;

	typedef enum logic [2:0] {
		ST_ACC,
		ST_LSTART,
		ST_DIV_LVL,
		ST_UPD,
		ST_ASTART,
		ST_DIV_AVG,
		ST_OUT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		state_d  = state_q;
		case (state_q)
			ST_ACC: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.acc = 1'b1;
					if (sts.close) begin
						state_d = ST_LSTART;
					end
				end
			end
			ST_LSTART: begin
				cmd.lvl_start = 1'b1;
				state_d       = ST_DIV_LVL;
			end
			ST_DIV_LVL: begin
				if (sts.div_done) begin
					cmd.lvl_cap = 1'b1;
					state_d     = ST_UPD;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_UPD: begin
				cmd.ring_upd = 1'b1;
				state_d      = ST_ASTART;
			end
			ST_ASTART: begin
				cmd.avg_start = 1'b1;
				state_d       = ST_DIV_AVG;
			end
			ST_DIV_AVG: begin
				if (sts.div_done) begin
					state_d = ST_OUT;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_ACC;
				end
			end
			default: begin
				state_d = ST_ACC;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
